// ----- rtl/cinorm_pkg.sv -----
// Shared constants for the complex int16 normalizer.
// No dependencies; used by the interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none
package cinorm_pkg;
   localparam int SCALE_BITS = 15;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 15'd16384;
endpackage
`default_nettype wire

// ----- rtl/cinorm_if.sv -----
// Valid/ready channel interfaces for the normalizer: sample, result and register write.
// Depends on cinorm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cinorm_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] in_real;
   logic signed [SAMPLE_WIDTH-1:0] in_imag;
   modport source (output valid, in_real, in_imag, input ready);
   modport sink   (input valid, in_real, in_imag, output ready);
endinterface

interface cinorm_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_real;
   logic signed [SAMPLE_WIDTH-1:0] out_imag;
   logic                           zero_input;
   modport source (output valid, out_real, out_imag, zero_input, input ready);
   modport sink   (input valid, out_real, out_imag, zero_input, output ready);
endinterface

interface cinorm_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [cinorm_pkg::SCALE_BITS-1:0]     target_scale;
   modport source (output valid, target_scale, input ready);
   modport sink   (input valid, target_scale, output ready);
endinterface
`default_nettype wire

// ----- rtl/complex_int16_normalizer_core.sv -----
// Complex sample normaliser: rescales (re, im) to a magnitude of target_scale LSBs.
// Depends on cinorm_pkg and the channel interfaces in cinorm_if.sv.
//
// Usage:
//   req : one complex sample per beat (in_real, in_imag), two's complement.
//   rsp : one result per beat (out_real, out_imag, zero_input), in input order.
//   csr : write of target_scale; always ready, to be written while idle.
// Pipeline stages: input register, squares and scaled parts, magnitude
// and squared numerator, fifteen restoring square-root-division stages (one
// quotient bit each, from a running remainder and a running k*M product),
// then a saturation/output register. One sample per cycle unless rsp stalls.
// A stall on rsp freezes the whole pipeline; req.ready drops in the same
// cycle, so no beat is lost or repeated. Reset empties the pipeline and
// sets target_scale to 16384.
`timescale 1ns / 1ps
`default_nettype none
module complex_int16_normalizer_core #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   cinorm_req_if.sink    req,
   cinorm_rsp_if.source  rsp,
   cinorm_csr_if.sink    csr
);
   localparam int W    = SAMPLE_WIDTH;
   localparam int SB   = cinorm_pkg::SCALE_BITS;
   localparam int MW   = 2 * W;
   localparam int NW   = W + SB;
   localparam int RW   = 2 * NW;
   localparam int PW   = MW + SB;
   localparam int TW   = RW + 2;
   localparam int CW   = W + SB;
   localparam logic [CW-1:0] LIM_NEG = CW'(1) << (W - 1);
   localparam logic [CW-1:0] LIM_POS = LIM_NEG - CW'(1);

   logic en;
   logic [SB-1:0] scale_ff;

   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= cinorm_pkg::SCALE_RESET;
      end else if (csr.valid) begin
         scale_ff <= csr.target_scale;
      end
   end

   // stage 1: magnitude and sign
   logic         v1_ff;
   logic [W-1:0] mag1_ff [0:1];
   logic         neg1_ff [0:1];
   // stage 2: squares and scaled parts
   logic          v2_ff;
   logic [MW-1:0] sq2_ff [0:1];
   logic [NW-1:0] n2_ff  [0:1];
   logic          neg2_ff [0:1];
   // bit stages, index 0 is the initial remainder
   logic          vb_ff   [0:SB];
   logic          zb_ff   [0:SB];
   logic [MW-1:0] mb_ff   [0:SB];
   logic [RW-1:0] rb_ff   [0:SB][0:1];
   logic [PW-1:0] pb_ff   [0:SB][0:1];
   logic [SB-1:0] kb_ff   [0:SB][0:1];
   logic          negb_ff [0:SB][0:1];

   logic [W-1:0] raw_w [0:1];
   assign raw_w[0] = req.in_real;
   assign raw_w[1] = req.in_imag;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         vb_ff[0] <= 1'b0;
      end else if (en) begin
         v1_ff    <= req.valid;
         v2_ff    <= v1_ff;
         vb_ff[0] <= v2_ff;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_front
      always_ff @(posedge clock) begin
         if (en) begin
            neg1_ff[l]    <= raw_w[l][W-1];
            mag1_ff[l]    <= raw_w[l][W-1] ? W'(-raw_w[l]) : raw_w[l];
            neg2_ff[l]    <= neg1_ff[l];
            sq2_ff[l]     <= MW'(mag1_ff[l]) * MW'(mag1_ff[l]);
            n2_ff[l]      <= NW'(mag1_ff[l]) * NW'(scale_ff);
            negb_ff[0][l] <= neg2_ff[l];
            rb_ff[0][l]   <= RW'(n2_ff[l]) * RW'(n2_ff[l]);
            pb_ff[0][l]   <= '0;
            kb_ff[0][l]   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mb_ff[0] <= sq2_ff[0] + sq2_ff[1];
         zb_ff[0] <= (sq2_ff[0] == '0) && (sq2_ff[1] == '0);
      end
   end

   // one quotient bit per stage: try k + 2^b against k^2*M <= N^2
   for (genvar j = 1; j <= SB; j++) begin : g_bit
      localparam int B = SB - j;
      always_ff @(posedge clock) begin
         if (reset) begin
            vb_ff[j] <= 1'b0;
         end else if (en) begin
            vb_ff[j] <= vb_ff[j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            mb_ff[j] <= mb_ff[j-1];
            zb_ff[j] <= zb_ff[j-1];
         end
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [TW-1:0] t_w;
         logic          fit_w;
         assign t_w   = (TW'(pb_ff[j-1][l]) << (B + 1)) + (TW'(mb_ff[j-1]) << (2 * B));
         assign fit_w = t_w <= TW'(rb_ff[j-1][l]);
         always_ff @(posedge clock) begin
            if (en) begin
               negb_ff[j][l] <= negb_ff[j-1][l];
               rb_ff[j][l]   <= fit_w ? RW'(TW'(rb_ff[j-1][l]) - t_w) : rb_ff[j-1][l];
               pb_ff[j][l]   <= fit_w ? pb_ff[j-1][l] + (PW'(mb_ff[j-1]) << B)
                                      : pb_ff[j-1][l];
               kb_ff[j][l]   <= kb_ff[j-1][l] | (SB'(fit_w) << B);
            end
         end
      end
   end

   // output: saturate and apply sign
   logic [W-1:0] res_w [0:1];
   for (genvar l = 0; l < 2; l++) begin : g_sat
      logic [CW-1:0] k_w;
      logic [CW-1:0] kc_w;
      assign k_w = CW'(kb_ff[SB][l]);
      always_comb begin
         if (negb_ff[SB][l]) begin
            kc_w     = (k_w > LIM_NEG) ? LIM_NEG : k_w;
            res_w[l] = W'(CW'(0) - kc_w);
         end else begin
            kc_w     = (k_w > LIM_POS) ? LIM_POS : k_w;
            res_w[l] = W'(kc_w);
         end
      end
   end

   logic         out_v_ff;
   logic [W-1:0] out_r_ff;
   logic [W-1:0] out_i_ff;
   logic         out_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= vb_ff[SB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_z_ff <= zb_ff[SB];
         out_r_ff <= zb_ff[SB] ? '0 : res_w[0];
         out_i_ff <= zb_ff[SB] ? '0 : res_w[1];
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.out_real   = out_r_ff;
   assign rsp.out_imag   = out_i_ff;
   assign rsp.zero_input = out_z_ff;
endmodule
`default_nettype wire
